// ===== hw/rtl/wlr_pkg.sv =====
// shared types, constants and the solver microcode for the regression block
// no dependencies; every rtl file of the block refers to it by scoped names
package wlr_pkg;

  // wide solver word, signed two's complement
  localparam int BW = 200;
  localparam int HW = BW / 2;
  localparam int CW = $clog2(BW + 1);

  // weight of one sample in q4.4, and the weight limit of 2.0
  localparam logic [7:0]  WEIGHT_ONE = 8'd16;
  localparam logic [23:0] WEIGHT_TWO = 24'd32;

  // sample queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // configuration register indexes
  localparam logic CFG_USE_WEIGHT = 1'b0;
  localparam logic CFG_MISSING    = 1'b1;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO_W  = 3'd1;
  localparam logic [2:0] ST_ZERO_VX = 3'd2;
  localparam logic [2:0] ST_ZERO_VY = 3'd3;
  localparam logic [2:0] ST_LOW_W   = 3'd4;

  // one classified sample
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         w;
    logic               take;
    logic               last;
  } sample_t;

  // head of the queue as seen by the back
  typedef struct packed {
    logic    valid;
    sample_t s;
  } qhead_t;

  // solver operations
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SUBZ  = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_DIVR  = 3'd4;
  localparam logic [2:0] OP_SQRTR = 3'd5;

  // solver register file slots
  localparam logic [3:0] R_W   = 4'd0;
  localparam logic [3:0] R_SX  = 4'd1;
  localparam logic [3:0] R_SY  = 4'd2;
  localparam logic [3:0] R_SXX = 4'd3;
  localparam logic [3:0] R_SYY = 4'd4;
  localparam logic [3:0] R_SXY = 4'd5;
  localparam logic [3:0] R_K2  = 4'd6;
  localparam logic [3:0] R_T1  = 4'd7;
  localparam logic [3:0] R_T2  = 4'd8;
  localparam logic [3:0] R_DXX = 4'd9;
  localparam logic [3:0] R_DYY = 4'd10;
  localparam logic [3:0] R_DXY = 4'd11;
  localparam logic [3:0] R_P   = 4'd12;
  localparam logic [3:0] R_D2  = 4'd13;
  localparam logic [3:0] R_N0  = 4'd14;
  localparam logic [3:0] R_Q   = 4'd15;

  // result taps taken at write-back
  localparam logic [3:0] TAP_NONE  = 4'd0;
  localparam logic [3:0] TAP_DXX   = 4'd1;
  localparam logic [3:0] TAP_DYY   = 4'd2;
  localparam logic [3:0] TAP_DXY   = 4'd3;
  localparam logic [3:0] TAP_SLOPE = 4'd4;
  localparam logic [3:0] TAP_ICPT  = 4'd5;
  localparam logic [3:0] TAP_R2    = 4'd6;
  localparam logic [3:0] TAP_CORR  = 4'd7;
  localparam logic [3:0] TAP_SE    = 4'd8;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] dst;
    logic [3:0] a;
    logic [3:0] b;
    logic [5:0] sh;
    logic [3:0] tap;
  } ustep_t;

  localparam int NSTEPS = 30;
  localparam int PCW    = $clog2(NSTEPS);
  localparam logic [PCW-1:0] PC_LAST = PCW'(NSTEPS - 1);

  function automatic ustep_t mk(input logic [2:0] op, input logic [3:0] dst,
                                input logic [3:0] a, input logic [3:0] b,
                                input logic [5:0] sh, input logic [3:0] tap);
    ustep_t s;
    s.op  = op;
    s.dst = dst;
    s.a   = a;
    s.b   = b;
    s.sh  = sh;
    s.tap = tap;
    return s;
  endfunction

  // solver program: differences, products, quotients and roots
  function automatic ustep_t ucode(input logic [PCW-1:0] pc);
    ustep_t s;
    case (pc)
      5'd0:  s = mk(OP_LOAD,  R_W,   R_W,   R_W,   6'd0,  TAP_NONE);
      5'd1:  s = mk(OP_LOAD,  R_SX,  R_SX,  R_SX,  6'd0,  TAP_NONE);
      5'd2:  s = mk(OP_LOAD,  R_SY,  R_SY,  R_SY,  6'd0,  TAP_NONE);
      5'd3:  s = mk(OP_LOAD,  R_SXX, R_SXX, R_SXX, 6'd0,  TAP_NONE);
      5'd4:  s = mk(OP_LOAD,  R_SYY, R_SYY, R_SYY, 6'd0,  TAP_NONE);
      5'd5:  s = mk(OP_LOAD,  R_SXY, R_SXY, R_SXY, 6'd0,  TAP_NONE);
      5'd6:  s = mk(OP_LOAD,  R_K2,  R_K2,  R_K2,  6'd0,  TAP_NONE);
      5'd7:  s = mk(OP_MUL,   R_T1,  R_W,   R_SXX, 6'd0,  TAP_NONE);
      5'd8:  s = mk(OP_MUL,   R_T2,  R_SX,  R_SX,  6'd0,  TAP_NONE);
      5'd9:  s = mk(OP_SUB,   R_DXX, R_T1,  R_T2,  6'd0,  TAP_DXX);
      5'd10: s = mk(OP_MUL,   R_T1,  R_W,   R_SYY, 6'd0,  TAP_NONE);
      5'd11: s = mk(OP_MUL,   R_T2,  R_SY,  R_SY,  6'd0,  TAP_NONE);
      5'd12: s = mk(OP_SUB,   R_DYY, R_T1,  R_T2,  6'd0,  TAP_DYY);
      5'd13: s = mk(OP_MUL,   R_T1,  R_W,   R_SXY, 6'd0,  TAP_NONE);
      5'd14: s = mk(OP_MUL,   R_T2,  R_SX,  R_SY,  6'd0,  TAP_NONE);
      5'd15: s = mk(OP_SUB,   R_DXY, R_T1,  R_T2,  6'd0,  TAP_DXY);
      5'd16: s = mk(OP_MUL,   R_P,   R_DXX, R_DYY, 6'd0,  TAP_NONE);
      5'd17: s = mk(OP_MUL,   R_D2,  R_DXY, R_DXY, 6'd0,  TAP_NONE);
      5'd18: s = mk(OP_MUL,   R_T1,  R_SY,  R_SXX, 6'd0,  TAP_NONE);
      5'd19: s = mk(OP_MUL,   R_T2,  R_SX,  R_SXY, 6'd0,  TAP_NONE);
      5'd20: s = mk(OP_SUB,   R_N0,  R_T1,  R_T2,  6'd0,  TAP_NONE);
      5'd21: s = mk(OP_DIVR,  R_T1,  R_DXY, R_DXX, 6'd16, TAP_SLOPE);
      5'd22: s = mk(OP_DIVR,  R_T1,  R_N0,  R_DXX, 6'd8,  TAP_ICPT);
      5'd23: s = mk(OP_DIVR,  R_T1,  R_D2,  R_P,   6'd16, TAP_R2);
      5'd24: s = mk(OP_SQRTR, R_T1,  R_D2,  R_P,   6'd32, TAP_CORR);
      5'd25: s = mk(OP_SUBZ,  R_Q,   R_P,   R_D2,  6'd0,  TAP_NONE);
      5'd26: s = mk(OP_MUL,   R_T1,  R_W,   R_DXX, 6'd0,  TAP_NONE);
      5'd27: s = mk(OP_SUB,   R_T2,  R_W,   R_K2,  6'd0,  TAP_NONE);
      5'd28: s = mk(OP_MUL,   R_T2,  R_T1,  R_T2,  6'd0,  TAP_NONE);
      5'd29: s = mk(OP_SQRTR, R_T1,  R_Q,   R_T2,  6'd16, TAP_SE);
      default: s = mk(OP_LOAD, R_T1, R_T1,  R_T1,  6'd0,  TAP_NONE);
    endcase
    return s;
  endfunction

  // saturate a wide signed word to signed 32 bits
  function automatic logic [31:0] sat_s32(input logic [BW-1:0] v);
    logic [31:0] r;
    if ((&v[BW-1:31]) || !(|v[BW-1:31])) begin
      r = v[31:0];
    end else if (v[BW-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // saturate a non-negative wide word to unsigned 31 bits
  function automatic logic [30:0] sat_u31(input logic [BW-1:0] v);
    logic [30:0] r;
    if (v[BW-1]) begin
      r = 31'd0;
    end else if (|v[BW-1:31]) begin
      r = 31'h7FFF_FFFF;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/weighted_linear_regression.sv =====
// top level of the weighted least-squares line fit
// depends on wlr_pkg, wlr_front, wlr_queue and wlr_back
//
// Usage:
//   Samples (x, y in q8.8, weight in q4.4, last) enter on start while busy is
//   low; one sample per cycle is taken as long as the four-entry queue has room.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets
//   use_weight (index 0) and the missing-value sentinel (index 1); it is always
//   ready. The user must write it only while the block is idle; the block
//   itself does not enforce this. Sums are kept through a three-stage product
//   pipeline at one sample a cycle while the solver is idle. The sample with
//   last set closes the set: a microcoded solver over 200-bit words then runs
//   30 steps on one shared unit (shift-add multiply, restoring divide at one
//   bit a cycle, digit-by-digit square root). The three divides and two roots
//   run over every bit, while a multiply ends once its remaining multiplier
//   bits are zero. Meanwhile busy rises once the queue fills. The result is
//   one out_valid beat carrying all fields; the receiver cannot stall, so it
//   must take that beat. The sums clear together with the beat.
//   Reset (rst_n low, synchronous) clears the sums, the queue and the solver,
//   and sets use_weight to 0 and the sentinel to -32768.
module weighted_linear_regression (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  in_x_value,
  input  logic signed [15:0]  in_y_value,
  input  logic [7:0]          in_weight,
  input  logic                in_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                out_valid,
  output logic signed [31:0]  out_intercept,
  output logic signed [31:0]  out_slope,
  output logic signed [31:0]  out_correlation,
  output logic signed [31:0]  out_r_squared,
  output logic [23:0]         out_total_weight,
  output logic [30:0]         out_residual_error,
  output logic [2:0]          out_status
);

  logic             q_full;
  logic             push;
  logic             pop;
  wlr_pkg::sample_t push_data;
  wlr_pkg::qhead_t  head;

  // accept and classify
  wlr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_x_value (in_x_value),
    .in_y_value (in_y_value),
    .in_weight  (in_weight),
    .in_last    (in_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  // decoupling queue
  wlr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .head      (head)
  );

  // sums and solver
  wlr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_intercept      (out_intercept),
    .out_slope          (out_slope),
    .out_correlation    (out_correlation),
    .out_r_squared      (out_r_squared),
    .out_total_weight   (out_total_weight),
    .out_residual_error (out_residual_error),
    .out_status         (out_status)
  );

endmodule

// ===== hw/rtl/wlr_front.sv =====
// front end: configuration registers, input beat acceptance and sample classification
// depends on wlr_pkg for the sample type and register indexes
module wlr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  in_x_value,
  input  logic signed [15:0]  in_y_value,
  input  logic [7:0]          in_weight,
  input  logic                in_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                q_full,
  output logic                push,
  output wlr_pkg::sample_t    push_data
);

  logic        use_weight_r;
  logic [15:0] missing_r;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_weight_r <= 1'b0;
      missing_r    <= 16'h8000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wlr_pkg::CFG_USE_WEIGHT: use_weight_r <= cfg_data[0];
        wlr_pkg::CFG_MISSING:    missing_r    <= cfg_data;
      endcase
    end
  end

  // accept while the queue has room
  assign busy = q_full;
  assign push = start && !q_full;

  // classify: mark missing samples to be skipped, pick the weight
  always_comb begin
    push_data.x    = in_x_value;
    push_data.y    = in_y_value;
    push_data.w    = use_weight_r ? in_weight : wlr_pkg::WEIGHT_ONE;
    push_data.take = (in_x_value != missing_r) && (in_y_value != missing_r);
    push_data.last = in_last;
  end

endmodule

// ===== hw/rtl/wlr_queue.sv =====
// short sample queue between front and back
// depends on wlr_pkg for the sample type and depth
module wlr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wlr_pkg::sample_t   push_data,
  input  logic               pop,
  output logic               full,
  output wlr_pkg::qhead_t    head
);

  wlr_pkg::sample_t         mem_r [wlr_pkg::QDEPTH];
  logic [wlr_pkg::QAW-1:0]  wr_ptr_r;
  logic [wlr_pkg::QAW-1:0]  rd_ptr_r;
  logic [wlr_pkg::QAW:0]    count_r;
  logic                     do_pop;

  assign full    = (count_r == (wlr_pkg::QAW+1)'(wlr_pkg::QDEPTH));
  assign do_pop  = pop && (count_r != '0);

  // head entry
  assign head.valid = (count_r != '0);
  assign head.s     = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/wlr_back.sv =====
// back end: weighted sum pipeline and the microcoded wide-word solver
// depends on wlr_pkg for types, microcode and saturation helpers
module wlr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wlr_pkg::qhead_t      head,
  output logic                 pop,
  output logic                 out_valid,
  output logic signed [31:0]   out_intercept,
  output logic signed [31:0]   out_slope,
  output logic signed [31:0]   out_correlation,
  output logic signed [31:0]   out_r_squared,
  output logic [23:0]          out_total_weight,
  output logic [30:0]          out_residual_error,
  output logic [2:0]           out_status
);

  localparam int BW = wlr_pkg::BW;
  localparam int HW = wlr_pkg::HW;
  localparam int CW = wlr_pkg::CW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]              state_r;
  logic [wlr_pkg::PCW-1:0] pc_r;
  logic                    hold_r;
  wlr_pkg::ustep_t         st;

  // product pipeline
  logic                a_vld_r, a_take_r, a_last_r;
  logic signed [15:0]  a_x_r, a_y_r;
  logic [7:0]          a_w_r;
  logic signed [24:0]  a_xw_r, a_yw_r;
  logic                b_vld_r, b_take_r, b_last_r;
  logic [7:0]          b_w_r;
  logic signed [24:0]  b_xw_r, b_yw_r;
  logic signed [40:0]  b_xxw_r, b_yyw_r, b_xyw_r;

  // weighted sums
  logic signed [40:0]  acc_x_r, acc_y_r;
  logic [55:0]         acc_xx_r, acc_yy_r;
  logic signed [56:0]  acc_xy_r;
  logic [23:0]         acc_w_r;

  // solver register file and unit state
  logic [BW-1:0]  rf_mem [16];
  logic [BW-1:0]  rd_a_r, rd_b_r;
  logic [BW-1:0]  res_r, ma_r, mb_r, prod_r, num_r, den_r, rem_r;
  logic           neg_r, sq_r;
  logic [CW-1:0]  cnt_r;
  logic [HW-1:0]  root_r;
  logic [HW+1:0]  srem_r;

  // results kept from taps
  logic           dxx_pos_r, dyy_pos_r, dxy_neg_r;
  logic [31:0]    slope_r, icpt_r, r2_r, corr_r;
  logic [30:0]    se_r;

  // combinational helpers
  logic [BW-1:0]  mag_a, mag_b, sh_a, sh_a2, load_v, diff;
  logic [BW:0]    rem_t;
  logic           ge;
  logic [BW-1:0]  rem_nxt, q_nxt;
  logic [HW+3:0]  sr_t, trial;
  logic           sge;
  logic [HW+1:0]  srem_nxt;
  logic [HW-1:0]  root_nxt;
  logic [HW:0]    rnd;
  logic [BW-1:0]  corr_v;
  logic           ok_x;

  assign st  = wlr_pkg::ucode(pc_r);
  assign pop = head.valid && (state_r == S_IDLE) && !hold_r;

  // operand magnitudes and shifts
  always_comb begin
    mag_a = rd_a_r[BW-1] ? -rd_a_r : rd_a_r;
    mag_b = rd_b_r[BW-1] ? -rd_b_r : rd_b_r;
    sh_a  = mag_a << st.sh;
    sh_a2 = mag_a << (7'(st.sh) + 7'd2);
    diff  = rd_a_r - rd_b_r;
  end

  // sums into the solver word
  always_comb begin
    unique case (st.a)
      wlr_pkg::R_W:   load_v = {{(BW-24){1'b0}}, acc_w_r};
      wlr_pkg::R_SX:  load_v = {{(BW-41){acc_x_r[40]}}, acc_x_r};
      wlr_pkg::R_SY:  load_v = {{(BW-41){acc_y_r[40]}}, acc_y_r};
      wlr_pkg::R_SXX: load_v = {{(BW-56){1'b0}}, acc_xx_r};
      wlr_pkg::R_SYY: load_v = {{(BW-56){1'b0}}, acc_yy_r};
      wlr_pkg::R_SXY: load_v = {{(BW-57){acc_xy_r[56]}}, acc_xy_r};
      wlr_pkg::R_K2:  load_v = {{(BW-24){1'b0}}, wlr_pkg::WEIGHT_TWO};
      default:        load_v = '0;
    endcase
  end

  // one restoring divide step
  always_comb begin
    rem_t   = {rem_r, num_r[BW-1]};
    ge      = (rem_t >= {1'b0, den_r});
    rem_nxt = ge ? BW'(rem_t - {1'b0, den_r}) : rem_t[BW-1:0];
    q_nxt   = {num_r[BW-2:0], ge};
  end

  // one square root digit step
  always_comb begin
    sr_t     = {srem_r, num_r[BW-1:BW-2]};
    trial    = {2'b00, root_r, 2'b01};
    sge      = (sr_t >= trial);
    srem_nxt = sge ? (HW+2)'(sr_t - trial) : sr_t[HW+1:0];
    root_nxt = {root_r[HW-2:0], sge};
    rnd      = {1'b0, root_nxt} + 1'b1;
    corr_v   = dxy_neg_r ? -res_r : res_r;
  end

  // stage a: weight products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    a_take_r <= head.s.take;
    a_last_r <= head.s.last;
    a_x_r    <= head.s.x;
    a_y_r    <= head.s.y;
    a_w_r    <= head.s.w;
    a_xw_r   <= $signed(head.s.x) * $signed({1'b0, head.s.w});
    a_yw_r   <= $signed(head.s.y) * $signed({1'b0, head.s.w});
  end

  // stage b: second-order products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_take_r <= a_take_r;
    b_last_r <= a_last_r;
    b_w_r    <= a_w_r;
    b_xw_r   <= a_xw_r;
    b_yw_r   <= a_yw_r;
    b_xxw_r  <= a_xw_r * a_x_r;
    b_yyw_r  <= a_yw_r * a_y_r;
    b_xyw_r  <= a_xw_r * a_y_r;
  end

  // accumulate, cleared once a result goes out
  always_ff @(posedge clk) begin
    if (!rst_n || state_r == S_DONE) begin
      acc_x_r  <= '0;
      acc_y_r  <= '0;
      acc_xx_r <= '0;
      acc_yy_r <= '0;
      acc_xy_r <= '0;
      acc_w_r  <= '0;
    end else if (b_vld_r && b_take_r) begin
      acc_x_r  <= acc_x_r + 41'(b_xw_r);
      acc_y_r  <= acc_y_r + 41'(b_yw_r);
      acc_xx_r <= acc_xx_r + 56'(b_xxw_r);
      acc_yy_r <= acc_yy_r + 56'(b_yyw_r);
      acc_xy_r <= acc_xy_r + 57'(b_xyw_r);
      acc_w_r  <= acc_w_r + 24'(b_w_r);
    end
  end

  // register file with registered reads
  always_ff @(posedge clk) begin
    rd_a_r <= rf_mem[st.a];
    rd_b_r <= rf_mem[st.b];
    if (state_r == S_WB) begin
      rf_mem[st.dst] <= res_r;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      hold_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (pop && head.s.last) begin
            hold_r <= 1'b1;
          end
          if (b_vld_r && b_last_r) begin
            pc_r    <= '0;
            state_r <= S_RD;
          end
        end
        S_RD:    state_r <= S_SETUP;
        S_SETUP: begin
          if (st.op == wlr_pkg::OP_LOAD || st.op == wlr_pkg::OP_SUB ||
              st.op == wlr_pkg::OP_SUBZ) begin
            state_r <= S_WB;
          end else begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (st.op == wlr_pkg::OP_MUL) begin
            if (mb_r == '0) state_r <= S_WB;
          end else if (cnt_r == CW'(1)) begin
            if (st.op == wlr_pkg::OP_DIVR || sq_r) state_r <= S_WB;
          end
        end
        S_WB: begin
          if (pc_r == wlr_pkg::PC_LAST) begin
            state_r <= S_DONE;
          end else begin
            pc_r    <= pc_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          hold_r  <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // solver datapath
  always_ff @(posedge clk) begin
    if (state_r == S_SETUP) begin
      neg_r  <= rd_a_r[BW-1] ^ rd_b_r[BW-1];
      sq_r   <= 1'b0;
      rem_r  <= '0;
      cnt_r  <= CW'(BW);
      prod_r <= '0;
      ma_r   <= mag_a;
      mb_r   <= mag_b;
      unique case (st.op)
        wlr_pkg::OP_LOAD: res_r <= load_v;
        wlr_pkg::OP_SUB:  res_r <= diff;
        wlr_pkg::OP_SUBZ: res_r <= diff[BW-1] ? '0 : diff;
        wlr_pkg::OP_DIVR: begin
          neg_r <= rd_a_r[BW-1];
          num_r <= (sh_a << 1) + mag_b;
          den_r <= mag_b << 1;
        end
        wlr_pkg::OP_SQRTR: begin
          num_r <= sh_a2;
          den_r <= mag_b;
        end
        default: ;
      endcase
    end else if (state_r == S_RUN) begin
      if (st.op == wlr_pkg::OP_MUL) begin
        // shift-and-add over the multiplier bits
        if (mb_r == '0) begin
          res_r <= neg_r ? -prod_r : prod_r;
        end else begin
          if (mb_r[0]) prod_r <= prod_r + ma_r;
          ma_r <= ma_r << 1;
          mb_r <= mb_r >> 1;
        end
      end else if (!sq_r) begin
        // divide, one quotient bit a cycle
        rem_r <= rem_nxt;
        num_r <= q_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          if (st.op == wlr_pkg::OP_DIVR) begin
            res_r <= neg_r ? -q_nxt : q_nxt;
          end else begin
            sq_r   <= 1'b1;
            cnt_r  <= CW'(HW);
            srem_r <= '0;
            root_r <= '0;
          end
        end
      end else begin
        // square root, one root bit a cycle, then round
        srem_r <= srem_nxt;
        root_r <= root_nxt;
        num_r  <= num_r << 2;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          res_r <= {{(BW-HW){1'b0}}, rnd[HW:1]};
        end
      end
    end
  end

  // taps on write-back
  always_ff @(posedge clk) begin
    if (state_r == S_WB) begin
      unique case (st.tap)
        wlr_pkg::TAP_DXX:   dxx_pos_r <= !res_r[BW-1] && (|res_r);
        wlr_pkg::TAP_DYY:   dyy_pos_r <= !res_r[BW-1] && (|res_r);
        wlr_pkg::TAP_DXY:   dxy_neg_r <= res_r[BW-1];
        wlr_pkg::TAP_SLOPE: slope_r   <= wlr_pkg::sat_s32(res_r);
        wlr_pkg::TAP_ICPT:  icpt_r    <= wlr_pkg::sat_s32(res_r);
        wlr_pkg::TAP_R2:    r2_r      <= wlr_pkg::sat_s32(res_r);
        wlr_pkg::TAP_CORR:  corr_r    <= wlr_pkg::sat_s32(corr_v);
        wlr_pkg::TAP_SE:    se_r      <= wlr_pkg::sat_u31(res_r);
        default: ;
      endcase
    end
  end

  // result beat
  assign ok_x = (acc_w_r != '0) && dxx_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_total_weight   <= acc_w_r;
      out_intercept      <= ok_x ? icpt_r : '0;
      out_slope          <= ok_x ? slope_r : '0;
      out_correlation    <= (ok_x && dyy_pos_r) ? corr_r : '0;
      out_r_squared      <= (ok_x && dyy_pos_r) ? r2_r : '0;
      out_residual_error <= (ok_x && acc_w_r > wlr_pkg::WEIGHT_TWO) ? se_r : '0;
      priority if (acc_w_r == '0) begin
        out_status <= wlr_pkg::ST_ZERO_W;
      end else if (!dxx_pos_r) begin
        out_status <= wlr_pkg::ST_ZERO_VX;
      end else if (!dyy_pos_r) begin
        out_status <= wlr_pkg::ST_ZERO_VY;
      end else if (acc_w_r <= wlr_pkg::WEIGHT_TWO) begin
        out_status <= wlr_pkg::ST_LOW_W;
      end else begin
        out_status <= wlr_pkg::ST_OK;
      end
    end
  end

endmodule

// ===== hw/rtl/wlr_checker.sv =====
// port-level checks on the regression block's result beats
// depends on wlr_pkg for status codes; bound to weighted_linear_regression
module wlr_props (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic signed [31:0] out_intercept,
  input logic signed [31:0] out_slope,
  input logic signed [31:0] out_correlation,
  input logic signed [31:0] out_r_squared,
  input logic [23:0]        out_total_weight,
  input logic [30:0]        out_residual_error,
  input logic [2:0]         out_status
);

  // result beats never come back to back
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beats back to back");

  // zero weight leaves the weight, slope, intercept, correlation and residual error at zero
  a_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == wlr_pkg::ST_ZERO_W |->
      out_total_weight == '0 && out_slope == '0 && out_intercept == '0 &&
      out_correlation == '0 && out_residual_error == '0)
    else $error("zero weight result not cleared");

  // no x variance clears the fit
  a_zero_vx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == wlr_pkg::ST_ZERO_VX |->
      out_slope == '0 && out_intercept == '0 && out_r_squared == '0 &&
      out_residual_error == '0)
    else $error("zero x variance result not cleared");

  // no y variance clears correlation terms
  a_zero_vy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == wlr_pkg::ST_ZERO_VY |->
      out_correlation == '0 && out_r_squared == '0)
    else $error("zero y variance correlation not cleared");

  // low weight gives no residual error
  a_low_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == wlr_pkg::ST_LOW_W |->
      out_residual_error == '0 && out_total_weight <= wlr_pkg::WEIGHT_TWO)
    else $error("low weight result inconsistent");

endmodule

bind weighted_linear_regression wlr_props u_wlr_props (.*);

// ===== sim/wlr_checker.sv =====
// result checker for the weighted line-fit block: predicts every fit from the
// accepted input beats and compares each output beat field by field
// depends on wlr_pkg for the status codes and configuration indexes
module wlr_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_x_value,
  input  logic signed [15:0] in_y_value,
  input  logic [7:0]         in_weight,
  input  logic               in_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               out_valid,
  input  logic signed [31:0] out_intercept,
  input  logic signed [31:0] out_slope,
  input  logic signed [31:0] out_correlation,
  input  logic signed [31:0] out_r_squared,
  input  logic [23:0]        out_total_weight,
  input  logic [30:0]        out_residual_error,
  input  logic [2:0]         out_status,
  output int                 errors,
  output int                 pending
);

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] intercept;
    logic signed [31:0] slope;
    logic signed [31:0] correlation;
    logic signed [31:0] r_squared;
    logic [23:0]        total_weight;
    logic [30:0]        residual_error;
    logic [2:0]         status;
  } fit_t;

  fit_t fit_q[$];

  // own copy of the configuration and the running sums
  logic        weighted;
  logic [15:0] sentinel;
  logic [40:0] sum_x, sum_y;
  logic [55:0] sum_xx, sum_yy;
  logic [56:0] sum_xy;
  logic [23:0] sum_w;

  // rounded quotient, divisor positive, ties away from zero
  function automatic wide_t div_round(input wide_t n, input wide_t d);
    wide_t m, q;
    m = (n < 0) ? -n : n;
    q = ((m <<< 1) + d) / (d <<< 1);
    return (n < 0) ? -q : q;
  endfunction

  // floor square root, result below 2^120
  function automatic wide_t isqrt(input wide_t n);
    wide_t r, c;
    r = 0;
    for (int k = 119; k >= 0; k--) begin
      c = r;
      c[k] = 1'b1;
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  // rounded square root of a quotient
  function automatic wide_t sqrt_round(input wide_t num, input wide_t den);
    wide_t s;
    s = isqrt((num <<< 2) / den);
    return (s + 1) / 2;
  endfunction

  function automatic wide_t clamp(input wide_t v, input wide_t lo, input wide_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // closes the data set: solves the fit from the current sums
  function automatic fit_t solve_fit();
    fit_t f;
    wide_t w, sx, sy, sxx, syy, sxy, dxx, dyy, dxy, p, d2, n0, q, d, m;
    wide_t lo32, hi32, w2;
    lo32 = -(wide_t'(1) <<< 31);
    hi32 = (wide_t'(1) <<< 31) - 1;
    w2 = 32;
    w = {232'b0, sum_w};
    sx = $signed(sum_x);
    sy = $signed(sum_y);
    sxx = {200'b0, sum_xx};
    syy = {200'b0, sum_yy};
    sxy = $signed(sum_xy);
    dxx = w * sxx - sx * sx;
    dyy = w * syy - sy * sy;
    dxy = w * sxy - sx * sy;
    p = dxx * dyy;
    d2 = dxy * dxy;
    f.intercept = 0;
    f.slope = 0;
    f.correlation = 0;
    f.r_squared = 0;
    f.residual_error = 0;
    f.total_weight = sum_w;
    if (w == 0) f.status = wlr_pkg::ST_ZERO_W;
    else if (dxx <= 0) f.status = wlr_pkg::ST_ZERO_VX;
    else if (dyy <= 0) f.status = wlr_pkg::ST_ZERO_VY;
    else if (w <= w2) f.status = wlr_pkg::ST_LOW_W;
    else f.status = wlr_pkg::ST_OK;
    if (w != 0 && dxx > 0) begin
      n0 = sy * sxx - sx * sxy;
      f.slope = 32'(clamp(div_round(dxy <<< 16, dxx), lo32, hi32));
      f.intercept = 32'(clamp(div_round(n0 <<< 8, dxx), lo32, hi32));
      if (dyy > 0) begin
        m = sqrt_round(d2 <<< 32, p);
        if (dxy < 0) m = -m;
        f.correlation = 32'(clamp(m, lo32, hi32));
        f.r_squared = 32'(clamp(div_round(d2 <<< 16, p), lo32, hi32));
      end
      if (w > w2) begin
        q = p - d2;
        if (q < 0) q = 0;
        d = w * dxx * (w - w2);
        f.residual_error = 31'(clamp(sqrt_round(q <<< 16, d), 0, hi32));
      end
    end
    return f;
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  assign pending = fit_q.size();

  initial errors = 0;

  // watch the three channels
  always @(posedge clk) begin
    fit_t want;
    logic signed [63:0] xs, ys, ws;
    if (!rst_n) begin
      weighted <= 1'b0;
      sentinel <= 16'h8000;
      sum_x = '0;
      sum_y = '0;
      sum_xx = '0;
      sum_yy = '0;
      sum_xy = '0;
      sum_w = '0;
      fit_q.delete();
    end else begin
      // configuration beat
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == wlr_pkg::CFG_USE_WEIGHT) weighted <= cfg_data[0];
        else sentinel <= cfg_data;
      end
      // result beat against the oldest prediction
      if (out_valid) begin
        if (fit_q.size() == 0) begin
          $display("result beat with no fit outstanding");
          errors++;
        end else begin
          want = fit_q.pop_front();
          if (out_intercept !== want.intercept)
            report("intercept", out_intercept, want.intercept);
          if (out_slope !== want.slope) report("slope", out_slope, want.slope);
          if (out_correlation !== want.correlation)
            report("correlation", out_correlation, want.correlation);
          if (out_r_squared !== want.r_squared)
            report("r_squared", out_r_squared, want.r_squared);
          if (out_total_weight !== want.total_weight)
            report("total_weight", out_total_weight, want.total_weight);
          if (out_residual_error !== want.residual_error)
            report("residual_error", out_residual_error, want.residual_error);
          if (out_status !== want.status) report("status", out_status, want.status);
        end
      end
      // sample beat: accumulate, and solve on the closing one
      if (start && !busy) begin
        xs = in_x_value;
        ys = in_y_value;
        ws = weighted ? {56'b0, in_weight} : 64'sd16;
        if (in_x_value != sentinel && in_y_value != sentinel) begin
          sum_x = sum_x + 41'(xs * ws);
          sum_y = sum_y + 41'(ys * ws);
          sum_xx = sum_xx + 56'(xs * xs * ws);
          sum_yy = sum_yy + 56'(ys * ys * ws);
          sum_xy = sum_xy + 57'(xs * ys * ws);
          sum_w = sum_w + 24'(ws);
        end
        if (in_last) begin
          fit_q.push_back(solve_fit());
          sum_x = '0;
          sum_y = '0;
          sum_xx = '0;
          sum_yy = '0;
          sum_xy = '0;
          sum_w = '0;
        end
      end
    end
  end

endmodule

// ===== sim/tb_weighted_linear_regression.sv =====
// top of the line-fit testbench: clock, reset, sample and configuration stimulus
// depends on wlr_pkg, the weighted_linear_regression rtl and wlr_checker
module tb_weighted_linear_regression;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_x_value;
  logic signed [15:0] in_y_value;
  logic [7:0]         in_weight;
  logic               in_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [15:0]        cfg_data;
  logic               out_valid;
  logic signed [31:0] out_intercept;
  logic signed [31:0] out_slope;
  logic signed [31:0] out_correlation;
  logic signed [31:0] out_r_squared;
  logic [23:0]        out_total_weight;
  logic [30:0]        out_residual_error;
  logic [2:0]         out_status;
  int                 errors;
  int                 pending;
  int                 idle_pct;
  int                 sent;
  logic [15:0]        sentinel;
  longint             cycles;

  weighted_linear_regression i_dut (.*);

  wlr_checker i_checker (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 12000000) begin
        $display("** weighted_linear_regression: FAILED **");
        $finish;
      end
    end
  end

  // one sample beat, with random idle cycles ahead of it
  task automatic send(input logic [15:0] x, input logic [15:0] y, input logic [7:0] w,
                      input logic last);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_x_value <= x;
    in_y_value <= y;
    in_weight <= w;
    in_last <= last;
    while (busy) @(negedge clk);
    sent++;
  endtask

  // hold the sender until every fit has come back
  task automatic drain(input int extra);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == wlr_pkg::CFG_MISSING) sentinel = data;
  endtask

  function automatic logic [15:0] pick_value(input logic narrow);
    int r;
    r = $urandom_range(99);
    if (r < 5) return sentinel;
    if (r < 12) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    if (narrow) return 16'($signed($urandom_range(1023)) - 512);
    return 16'($urandom);
  endfunction

  // well-formed data sets with random content, some flat in x or y
  task automatic random_sets(input int count);
    int len, kind;
    logic narrow;
    logic [15:0] fx, fy;
    count = sent + count;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 24);
      kind = $urandom_range(19);
      narrow = 1'($urandom_range(1));
      fx = pick_value(narrow);
      fy = pick_value(narrow);
      for (int i = 0; i < len; i++)
        send(kind == 0 ? fx : pick_value(narrow), kind == 1 ? fy : pick_value(narrow),
             $urandom_range(9) == 0 ? 8'd0 : 8'($urandom), i == len - 1);
      if ($urandom_range(29) == 0) drain(0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_x_value = '0;
    in_y_value = '0;
    in_weight = '0;
    in_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = wlr_pkg::CFG_USE_WEIGHT;
    cfg_data = '0;
    sentinel = 16'h8000;
    idle_pct = 19;
    sent = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed sets under reset configuration
    send(16'h0100, 16'h0200, 8'd0, 1'b1);
    send(16'h8000, 16'h0100, 8'd5, 1'b1);
    send(16'h0100, 16'h0100, 8'd9, 1'b0);
    send(16'h0100, 16'h0300, 8'd9, 1'b0);
    send(16'h0100, 16'hFF00, 8'd9, 1'b1);
    send(16'h0100, 16'h0040, 8'd1, 1'b0);
    send(16'h0300, 16'h0040, 8'd1, 1'b0);
    send(16'hFE00, 16'h0040, 8'd1, 1'b1);
    send(16'h7FFF, 16'h7FFF, 8'd1, 1'b0);
    send(16'h8001, 16'h8001, 8'd1, 1'b0);
    send(16'h0000, 16'h8001, 8'd1, 1'b1);
    drain(50);

    // weighted mode, sentinel at the top of the range
    cfg_write(wlr_pkg::CFG_USE_WEIGHT, 16'd1);
    cfg_write(wlr_pkg::CFG_MISSING, 16'h7FFF);
    send(16'h8000, 16'h8000, 8'd255, 1'b0);
    send(16'h7FFE, 16'h1234, 8'd0, 1'b0);
    send(16'h7FFF, 16'h0100, 8'd200, 1'b0);
    send(16'h0100, 16'h7FFE, 8'd255, 1'b1);
    send(16'h0100, 16'h0200, 8'd1, 1'b0);
    send(16'h0200, 16'h0100, 8'd1, 1'b1);
    send(16'h0500, 16'h0200, 8'd0, 1'b1);
    drain(50);

    // unweighted, default sentinel
    cfg_write(wlr_pkg::CFG_USE_WEIGHT, 16'd0);
    cfg_write(wlr_pkg::CFG_MISSING, 16'h8000);
    random_sets(460);
    drain(50);

    // weighted, sentinel at the top, sender rarely ready
    idle_pct = 67;
    cfg_write(wlr_pkg::CFG_USE_WEIGHT, 16'd1);
    cfg_write(wlr_pkg::CFG_MISSING, 16'h7FFF);
    random_sets(460);
    drain(50);

    // weighted, random sentinel, back to back beats
    idle_pct = 0;
    cfg_write(wlr_pkg::CFG_MISSING, 16'($urandom));
    random_sets(460);

    drain(200);
    if (errors == 0) begin
      $display("** weighted_linear_regression: PASSED **");
    end else begin
      $display("** weighted_linear_regression: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wlr_pkg.sv
hw/rtl/wlr_front.sv
hw/rtl/wlr_queue.sv
hw/rtl/wlr_back.sv
hw/rtl/weighted_linear_regression.sv
hw/rtl/wlr_checker.sv
sim/wlr_checker.sv
sim/tb_weighted_linear_regression.sv
